// File: rtl/size_class_page_allocator_core_defines.svh
// Assertion macros for the page allocator core.
`ifndef SIZE_CLASS_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define SIZE_CLASS_PAGE_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define SCPA_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SCPA_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/scpa_pkg.sv
// Shared constants, types and command codes of the page allocator core.
package scpa_pkg;
	localparam int NUM_PAGES       = 4;
	localparam int PAGE_BYTES      = 4096;
	localparam int MIN_CLASS_BYTES = 16;

	localparam int ADDR_W   = 14;
	localparam int SIZE_W   = 16;
	localparam int STS_W    = 2;
	localparam int PG_W     = $clog2(NUM_PAGES);
	localparam int NXT_W    = $clog2(NUM_PAGES + 1);
	localparam int FC_W     = NXT_W;
	localparam int PAGE_SH  = $clog2(PAGE_BYTES);
	localparam int MIN_SH   = $clog2(MIN_CLASS_BYTES);
	localparam int UNITS    = PAGE_BYTES / MIN_CLASS_BYTES;
	localparam int UNIT_W   = $clog2(UNITS);
	localparam int CNT_W    = UNIT_W + 1;
	localparam int WBITS    = 16;
	localparam int BIT_SH   = $clog2(WBITS);
	localparam int WORDS    = UNITS / WBITS;
	localparam int WORD_W   = $clog2(WORDS);
	localparam int MEM_AW   = PG_W + WORD_W;
	localparam int MEM_D    = NUM_PAGES * WORDS;
	localparam int NUM_CLASSES = $clog2(PAGE_BYTES / 2 / MIN_CLASS_BYTES) + 1;
	localparam int CLS_W    = $clog2(NUM_CLASSES);
	localparam int MPG_W    = $clog2((65535 + PAGE_BYTES - 1) / PAGE_BYTES + 1);
	localparam int NO_PAGE  = NUM_PAGES;

	localparam logic [1:0] KIND_FREE = 2'd0;
	localparam logic [1:0] KIND_DIV  = 2'd1;
	localparam logic [1:0] KIND_MULTI = 2'd2;

	localparam logic [STS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STS_W-1:0] ST_OOM  = 2'd1;
	localparam logic [STS_W-1:0] ST_IGN  = 2'd2;

	localparam int CMD_W = 4;
	localparam logic [CMD_W-1:0] CMD_NONE    = 4'd0;
	localparam logic [CMD_W-1:0] CMD_LATCH   = 4'd1;
	localparam logic [CMD_W-1:0] CMD_NEWPAGE = 4'd2;
	localparam logic [CMD_W-1:0] CMD_SINIT   = 4'd3;
	localparam logic [CMD_W-1:0] CMD_GRANT   = 4'd4;
	localparam logic [CMD_W-1:0] CMD_FAILREM = 4'd5;
	localparam logic [CMD_W-1:0] CMD_NEXTW   = 4'd6;
	localparam logic [CMD_W-1:0] CMD_MPOP    = 4'd7;
	localparam logic [CMD_W-1:0] CMD_FCLR    = 4'd8;
	localparam logic [CMD_W-1:0] CMD_FTAIL   = 4'd9;
	localparam logic [CMD_W-1:0] CMD_UNLINK  = 4'd10;
	localparam logic [CMD_W-1:0] CMD_WALK    = 4'd11;
	localparam logic [CMD_W-1:0] CMD_SETOOM  = 4'd12;
	localparam logic [CMD_W-1:0] CMD_SETIGN  = 4'd13;
	localparam logic [CMD_W-1:0] CMD_FINISH  = 4'd14;

	typedef struct packed {
		logic              mode;
		logic [SIZE_W-1:0] req_size;
		logic [ADDR_W-1:0] req_addr;
	} in_word_t;

	typedef struct packed {
		logic [ADDR_W-1:0] result_addr;
		logic [STS_W-1:0]  status;
	} out_word_t;

	typedef struct packed {
		logic is_free;
		logic is_small;
		logic oom_small;
		logic need_page;
		logic oom_multi;
		logic free_bad;
		logic free_div;
		logic found;
		logic last_word;
		logic multi_last;
		logic walk_done;
		logic out_free;
	} sts_t;
endpackage

// File: rtl/size_class_page_allocator_core.sv
// A small alloc scans the bitmap words of a page in turn, up to 16 words of a page; a
// multipage alloc takes one page at a time from the free page queue; a free either clears
// a class block or walks the chained pages; out of memory at decode or an ignored free goes straight to the result.
// One request word at a time; the result word sits in an output register and the next
// request enters while it waits. Reset: asynchronous, clears page tables, queue, class
// counts and bitmap row valid bits; ready right after reset, no clearing pass.
`include "size_class_page_allocator_core_defines.svh"
module size_class_page_allocator_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  scpa_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output scpa_pkg::out_word_t out_word
);
	logic [scpa_pkg::CMD_W-1:0] cmd;
	scpa_pkg::sts_t             sts;

	scpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	scpa_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_word   (in_word),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	`SCPA_AST_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
	`SCPA_AST_NXT(a_finish_loads_out, cmd == scpa_pkg::CMD_FINISH, out_valid, "result lost")
	`SCPA_AST_IMP(a_grant_found, cmd == scpa_pkg::CMD_GRANT, sts.found, "grant without free block")
endmodule

// File: rtl/scpa_dpath.sv
// Datapath: page tables, free page queue, class lists, block bitmap and result register.
module scpa_dpath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [scpa_pkg::CMD_W-1:0] cmd,
	input  scpa_pkg::in_word_t        in_word,
	output scpa_pkg::sts_t            sts,
	output logic                      out_valid,
	input  logic                      out_ready,
	output scpa_pkg::out_word_t       out_word
);
	localparam int N = scpa_pkg::NUM_PAGES;
	localparam int PG_W = scpa_pkg::PG_W;
	localparam int NXT_W = scpa_pkg::NXT_W;
	localparam int FC_W = scpa_pkg::FC_W;
	localparam int CLS_W = scpa_pkg::CLS_W;
	localparam int NC = scpa_pkg::NUM_CLASSES;
	localparam int WBITS = scpa_pkg::WBITS;
	localparam int BIT_SH = scpa_pkg::BIT_SH;
	localparam int WORD_W = scpa_pkg::WORD_W;
	localparam int UNIT_W = scpa_pkg::UNIT_W;
	localparam int CNT_W = scpa_pkg::CNT_W;
	localparam int ADDR_W = scpa_pkg::ADDR_W;
	localparam int PAGE_SH = scpa_pkg::PAGE_SH;
	localparam int MIN_SH = scpa_pkg::MIN_SH;
	localparam int MPG_W = scpa_pkg::MPG_W;
	localparam int SZ1_W = scpa_pkg::SIZE_W + 1;

	typedef logic [N-1:0][PG_W-1:0] pg_row_t;
	typedef struct packed {
		pg_row_t         pg;
		logic [FC_W-1:0] cnt;
	} row_t;

	function automatic row_t list_remove(pg_row_t r, logic [FC_W-1:0] c, logic [PG_W-1:0] p);
		row_t o;
		logic [FC_W-1:0] j;
		o.pg = r;
		j = '0;
		for (int i = 0; i < N; i++) begin
			if (FC_W'(i) < c && r[i] != p) begin
				o.pg[j[PG_W-1:0]] = r[i];
				j = j + 1'b1;
			end
		end
		o.cnt = j;
		return o;
	endfunction

	// state
	logic [1:0]        kind_q [N];
	logic [CLS_W-1:0]  pcls_q [N];
	logic [NXT_W-1:0]  pnxt_q [N];
	logic [CNT_W-1:0]  pcnt_q [N];
	logic [PG_W-1:0]   fq_q [N];
	logic [FC_W-1:0]   fc_q;
	pg_row_t           cls_pg_q [NC];
	logic [FC_W-1:0]   cls_cnt_q [NC];

	// request working registers
	logic              free_q, small_q;
	logic [CLS_W-1:0]  k_q;
	logic [PG_W-1:0]   pg_q;
	logic [NXT_W-1:0]  pw_q, prev_q, steps_q;
	logic [WORD_W-1:0] w_q;
	logic [BIT_SH-1:0] b_q;
	logic [MPG_W-1:0]  rem_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [scpa_pkg::STS_W-1:0] res_sts_q;
	logic              out_valid_q;
	scpa_pkg::out_word_t out_q;

	// bitmap memory with row valid bits
	logic [WBITS-1:0]  mem [scpa_pkg::MEM_D];
	logic [scpa_pkg::MEM_D-1:0] row_vld_q;
	logic [WBITS-1:0]  rd_q;
	logic              rdv_q;
	logic [scpa_pkg::MEM_AW-1:0] maddr;
	logic              mwe;
	logic [WBITS-1:0]  mwd;

	assign maddr = {pg_q, w_q};

	always_ff @(posedge clk) begin
		rd_q <= mem[maddr];
		if (mwe)
			mem[maddr] <= mwd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rdv_q <= 1'b0;
		end else begin
			rdv_q <= row_vld_q[maddr];
			if (mwe)
				row_vld_q[maddr] <= 1'b1;
		end
	end

	// decode of the incoming word
	logic [SZ1_W-1:0]  need_c;
	logic [CLS_W-1:0]  k_c, kf_c;
	logic [MPG_W-1:0]  mpg_c;
	logic [PG_W-1:0]   fp_c;
	logic [UNIT_W-1:0] fu_c;
	logic [SZ1_W-1:0]  mpg_sum;

	always_comb begin
		need_c = SZ1_W'(in_word.req_size) + 1'b1;
		k_c = '0;
		for (int i = 0; i < NC - 1; i++)
			if (SZ1_W'(scpa_pkg::MIN_CLASS_BYTES << i) < need_c)
				k_c = k_c + 1'b1;
		mpg_sum = SZ1_W'(in_word.req_size) + SZ1_W'(scpa_pkg::PAGE_BYTES - 1);
		mpg_c = MPG_W'(mpg_sum >> PAGE_SH);
		fp_c = in_word.req_addr[ADDR_W-1:PAGE_SH];
		kf_c = pcls_q[fp_c];
		fu_c = in_word.req_addr[PAGE_SH-1:MIN_SH] & ~((UNIT_W'(1) << kf_c) - 1'b1);
	end

	// word scan
	logic [WBITS-1:0]  wd, mask, cand;
	logic [BIT_SH-1:0] fb;
	logic [WORD_W:0]   stride;
	logic [CNT_W-1:0]  nblk;
	logic              walk_ok;

	always_comb begin
		wd = rdv_q ? rd_q : '0;
		for (int b = 0; b < WBITS; b++) begin
			if (k_q < CLS_W'(BIT_SH))
				mask[b] = ((BIT_SH'(b) & ((BIT_SH'(1) << k_q) - 1'b1)) == '0);
			else
				mask[b] = (b == 0);
		end
		cand = ~wd & mask;
		fb = '0;
		for (int b = WBITS - 1; b >= 0; b--)
			if (cand[b])
				fb = BIT_SH'(b);
		if (k_q < CLS_W'(BIT_SH))
			stride = (WORD_W + 1)'(1);
		else
			stride = (WORD_W + 1)'(1) << (k_q - CLS_W'(BIT_SH));
		nblk = CNT_W'(scpa_pkg::UNITS) >> k_q;
		walk_ok = (pw_q < NXT_W'(N)) && (kind_q[pw_q[PG_W-1:0]] == scpa_pkg::KIND_MULTI);
	end

	logic has_c;
	row_t rem_row;
	always_comb begin
		has_c = 1'b0;
		for (int i = 0; i < N; i++)
			if (FC_W'(i) < cls_cnt_q[k_q] && cls_pg_q[k_q][i] == pg_q)
				has_c = 1'b1;
		rem_row = list_remove(cls_pg_q[k_q], cls_cnt_q[k_q], pg_q);
	end

	always_comb begin
		mwe = 1'b0;
		mwd = wd;
		if (cmd == scpa_pkg::CMD_GRANT) begin
			mwe = 1'b1;
			mwd = wd | (WBITS'(1) << fb);
		end else if (cmd == scpa_pkg::CMD_FCLR) begin
			mwe = 1'b1;
			mwd = wd & ~(WBITS'(1) << b_q);
		end
	end

	always_comb begin
		sts.is_free    = free_q;
		sts.is_small   = small_q;
		sts.need_page  = (cls_cnt_q[k_q] == '0);
		sts.oom_small  = (cls_cnt_q[k_q] == '0) && (fc_q == '0);
		sts.oom_multi  = (rem_q > MPG_W'(fc_q));
		sts.free_bad   = (kind_q[pg_q] == scpa_pkg::KIND_FREE);
		sts.free_div   = (kind_q[pg_q] == scpa_pkg::KIND_DIV);
		sts.found      = |cand;
		sts.last_word  = ({1'b0, w_q} + stride) >= (WORD_W + 1)'(scpa_pkg::WORDS);
		sts.multi_last = (rem_q == MPG_W'(1));
		sts.walk_done  = !walk_ok || (steps_q == NXT_W'(N));
		sts.out_free   = !out_valid_q || out_ready;
	end

	// class list entries and working registers: no reset needed
	always_ff @(posedge clk) begin
		case (cmd)
			scpa_pkg::CMD_LATCH: begin
				free_q  <= in_word.mode;
				small_q <= (need_c <= SZ1_W'(scpa_pkg::PAGE_BYTES / 2));
				k_q     <= in_word.mode ? kf_c : k_c;
				pg_q    <= fp_c;
				pw_q    <= NXT_W'(fp_c);
				prev_q  <= NXT_W'(scpa_pkg::NO_PAGE);
				steps_q <= '0;
				w_q     <= fu_c[UNIT_W-1:BIT_SH];
				b_q     <= fu_c[BIT_SH-1:0];
				rem_q   <= mpg_c;
				res_sts_q <= scpa_pkg::ST_DONE;
				if (!in_word.mode &&
				    !(need_c <= SZ1_W'(scpa_pkg::PAGE_BYTES / 2)))
					res_addr_q <= ADDR_W'(fq_q[0]) << PAGE_SH;
				else
					res_addr_q <= '0;
			end
			scpa_pkg::CMD_NEWPAGE: cls_pg_q[k_q][cls_cnt_q[k_q][PG_W-1:0]] <= fq_q[0];
			scpa_pkg::CMD_SINIT: begin
				pg_q <= cls_pg_q[k_q][0];
				w_q  <= '0;
			end
			scpa_pkg::CMD_NEXTW: w_q <= w_q + stride[WORD_W-1:0];
			scpa_pkg::CMD_GRANT: begin
				res_addr_q <= (ADDR_W'(pg_q) << PAGE_SH) +
					(ADDR_W'({w_q, fb}) << MIN_SH) + ADDR_W'(1);
				if (pcnt_q[pg_q] + 1'b1 == nblk)
					cls_pg_q[k_q] <= rem_row.pg;
			end
			scpa_pkg::CMD_FAILREM: begin
				cls_pg_q[k_q] <= rem_row.pg;
				res_sts_q <= scpa_pkg::ST_OOM;
			end
			scpa_pkg::CMD_MPOP: begin
				prev_q <= NXT_W'(fq_q[0]);
				rem_q  <= rem_q - 1'b1;
			end
			scpa_pkg::CMD_FTAIL: begin
				if (pcnt_q[pg_q] == '0)
					cls_pg_q[k_q] <= rem_row.pg;
				else if (!has_c && cls_cnt_q[k_q] < FC_W'(N))
					cls_pg_q[k_q][cls_cnt_q[k_q][PG_W-1:0]] <= pg_q;
			end
			scpa_pkg::CMD_WALK: begin
				pw_q    <= pnxt_q[pw_q[PG_W-1:0]];
				steps_q <= steps_q + 1'b1;
			end
			scpa_pkg::CMD_SETOOM: begin
				res_sts_q  <= scpa_pkg::ST_OOM;
				res_addr_q <= '0;
			end
			scpa_pkg::CMD_SETIGN: res_sts_q <= scpa_pkg::ST_IGN;
			scpa_pkg::CMD_FINISH: begin
				out_q.result_addr <= res_addr_q;
				out_q.status      <= res_sts_q;
			end
			default: ;
		endcase
	end

	// page tables, queue and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < N; p++) begin
				kind_q[p] <= scpa_pkg::KIND_FREE;
				pcls_q[p] <= '0;
				pnxt_q[p] <= NXT_W'(scpa_pkg::NO_PAGE);
				pcnt_q[p] <= '0;
				fq_q[p]   <= PG_W'(p);
			end
			fc_q <= FC_W'(N);
			for (int c = 0; c < NC; c++)
				cls_cnt_q[c] <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd == scpa_pkg::CMD_FINISH)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (cmd)
				scpa_pkg::CMD_NEWPAGE: begin
					kind_q[fq_q[0]] <= scpa_pkg::KIND_DIV;
					pcls_q[fq_q[0]] <= k_q;
					pnxt_q[fq_q[0]] <= NXT_W'(scpa_pkg::NO_PAGE);
					pcnt_q[fq_q[0]] <= '0;
					for (int i = 0; i < N - 1; i++)
						fq_q[i] <= fq_q[i+1];
					fc_q <= fc_q - 1'b1;
					cls_cnt_q[k_q] <= cls_cnt_q[k_q] + 1'b1;
				end
				scpa_pkg::CMD_GRANT: begin
					pcnt_q[pg_q] <= pcnt_q[pg_q] + 1'b1;
					if (pcnt_q[pg_q] + 1'b1 == nblk)
						cls_cnt_q[k_q] <= rem_row.cnt;
				end
				scpa_pkg::CMD_FAILREM: cls_cnt_q[k_q] <= rem_row.cnt;
				scpa_pkg::CMD_MPOP: begin
					kind_q[fq_q[0]] <= scpa_pkg::KIND_MULTI;
					pcls_q[fq_q[0]] <= '0;
					pnxt_q[fq_q[0]] <= NXT_W'(scpa_pkg::NO_PAGE);
					if (prev_q < NXT_W'(N))
						pnxt_q[prev_q[PG_W-1:0]] <= NXT_W'(fq_q[0]);
					for (int i = 0; i < N - 1; i++)
						fq_q[i] <= fq_q[i+1];
					fc_q <= fc_q - 1'b1;
				end
				scpa_pkg::CMD_FCLR:
					if (wd[b_q])
						pcnt_q[pg_q] <= pcnt_q[pg_q] - 1'b1;
				scpa_pkg::CMD_FTAIL: begin
					if (pcnt_q[pg_q] == '0) begin
						cls_cnt_q[k_q] <= rem_row.cnt;
						kind_q[pg_q] <= scpa_pkg::KIND_FREE;
						pcls_q[pg_q] <= '0;
						if (fc_q < FC_W'(N)) begin
							fq_q[fc_q[PG_W-1:0]] <= pg_q;
							fc_q <= fc_q + 1'b1;
						end
					end else if (!has_c && cls_cnt_q[k_q] < FC_W'(N)) begin
						cls_cnt_q[k_q] <= cls_cnt_q[k_q] + 1'b1;
					end
				end
				scpa_pkg::CMD_UNLINK:
					for (int q = 0; q < N; q++)
						if (kind_q[q] == scpa_pkg::KIND_MULTI && pnxt_q[q] == NXT_W'(pg_q))
							pnxt_q[q] <= NXT_W'(scpa_pkg::NO_PAGE);
				scpa_pkg::CMD_WALK: begin
					kind_q[pw_q[PG_W-1:0]] <= scpa_pkg::KIND_FREE;
					pcls_q[pw_q[PG_W-1:0]] <= '0;
					pnxt_q[pw_q[PG_W-1:0]] <= NXT_W'(scpa_pkg::NO_PAGE);
					if (fc_q < FC_W'(N)) begin
						fq_q[fc_q[PG_W-1:0]] <= pw_q[PG_W-1:0];
						fc_q <= fc_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;
endmodule

// File: rtl/scpa_ctrl.sv
// Controller: sequences each request word through the datapath.
module scpa_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  scpa_pkg::sts_t             sts,
	output logic [scpa_pkg::CMD_W-1:0] cmd
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_SINIT = 4'd2;
	localparam logic [3:0] S_RD    = 4'd3;
	localparam logic [3:0] S_EV    = 4'd4;
	localparam logic [3:0] S_MPOP  = 4'd5;
	localparam logic [3:0] S_FRD   = 4'd6;
	localparam logic [3:0] S_FCLR  = 4'd7;
	localparam logic [3:0] S_FTAIL = 4'd8;
	localparam logic [3:0] S_WALK  = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;

	logic [3:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = scpa_pkg::CMD_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd = scpa_pkg::CMD_LATCH;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.is_free) begin
					if (sts.free_bad) begin
						cmd = scpa_pkg::CMD_SETIGN;
						state_d = S_FIN;
					end else if (sts.free_div) begin
						state_d = S_FRD;
					end else begin
						cmd = scpa_pkg::CMD_UNLINK;
						state_d = S_WALK;
					end
				end else if (sts.is_small) begin
					if (sts.oom_small) begin
						cmd = scpa_pkg::CMD_SETOOM;
						state_d = S_FIN;
					end else begin
						if (sts.need_page)
							cmd = scpa_pkg::CMD_NEWPAGE;
						state_d = S_SINIT;
					end
				end else if (sts.oom_multi) begin
					cmd = scpa_pkg::CMD_SETOOM;
					state_d = S_FIN;
				end else begin
					state_d = S_MPOP;
				end
			end
			S_SINIT: begin
				cmd = scpa_pkg::CMD_SINIT;
				state_d = S_RD;
			end
			S_RD: state_d = S_EV;
			S_EV: begin
				if (sts.found) begin
					cmd = scpa_pkg::CMD_GRANT;
					state_d = S_FIN;
				end else if (sts.last_word) begin
					cmd = scpa_pkg::CMD_FAILREM;
					state_d = S_FIN;
				end else begin
					cmd = scpa_pkg::CMD_NEXTW;
					state_d = S_RD;
				end
			end
			S_MPOP: begin
				cmd = scpa_pkg::CMD_MPOP;
				if (sts.multi_last)
					state_d = S_FIN;
			end
			S_FRD: state_d = S_FCLR;
			S_FCLR: begin
				cmd = scpa_pkg::CMD_FCLR;
				state_d = S_FTAIL;
			end
			S_FTAIL: begin
				cmd = scpa_pkg::CMD_FTAIL;
				state_d = S_FIN;
			end
			S_WALK: begin
				if (sts.walk_done)
					state_d = S_FIN;
				else
					cmd = scpa_pkg::CMD_WALK;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd = scpa_pkg::CMD_FINISH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end
endmodule

// File: dv/tb_size_class_page_allocator_core.sv
// Testbench for the size-class page allocator core: scoreboard prediction with random stalls.
`timescale 1ns / 100ps
module tb_size_class_page_allocator_core;
	localparam int NUM_PAGES       = scpa_pkg::NUM_PAGES;
	localparam int PAGE_BYTES      = scpa_pkg::PAGE_BYTES;
	localparam int MIN_CLASS_BYTES = scpa_pkg::MIN_CLASS_BYTES;
	localparam int UNITS           = scpa_pkg::UNITS;
	localparam int NO_PAGE         = scpa_pkg::NO_PAGE;
	localparam int ADDR_W          = scpa_pkg::ADDR_W;
	localparam int SIZE_W          = scpa_pkg::SIZE_W;
	localparam logic [1:0] KIND_FREE  = scpa_pkg::KIND_FREE;
	localparam logic [1:0] KIND_DIV   = scpa_pkg::KIND_DIV;
	localparam logic [1:0] KIND_MULTI = scpa_pkg::KIND_MULTI;
	localparam logic [scpa_pkg::STS_W-1:0] ST_DONE = scpa_pkg::ST_DONE;
	localparam logic [scpa_pkg::STS_W-1:0] ST_OOM  = scpa_pkg::ST_OOM;
	localparam logic [scpa_pkg::STS_W-1:0] ST_IGN  = scpa_pkg::ST_IGN;
	typedef scpa_pkg::in_word_t  in_word_t;
	typedef scpa_pkg::out_word_t out_word_t;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;
	localparam int   CYCLE_LIMIT = 900000;

	class alloc_scoreboard;
		logic [1:0] kind [NUM_PAGES];
		int         cls [NUM_PAGES];
		int         nxt [NUM_PAGES];
		bit         busy [NUM_PAGES*UNITS];
		int         fifo [$];
		int         clist [8][$];
		out_word_t  awaited [$];
		int         errors, checked, grants, ooms, ignores;

		function void clear();
			for (int p = 0; p < NUM_PAGES; p++) begin
				kind[p] = KIND_FREE;
				cls[p] = 0;
				nxt[p] = NO_PAGE;
			end
			foreach (busy[u]) busy[u] = 0;
			fifo.delete();
			for (int p = 0; p < NUM_PAGES; p++) fifo = {fifo, p};
			for (int k = 0; k < 8; k++) clist[k].delete();
		endfunction

		function int lowest(int p, int k);
			for (int j = 0; j < (UNITS >> k); j++)
				if (!busy[p*UNITS + (j << k)]) return j;
			return -1;
		endfunction

		function bit listed(int k, int p);
			foreach (clist[k][i]) if (clist[k][i] == p) return 1;
			return 0;
		endfunction

		function void unlist(int k, int p);
			for (int i = clist[k].size() - 1; i >= 0; i--)
				if (clist[k][i] == p) clist[k].delete(i);
		endfunction

		// returns the expected result and queues it
		function out_word_t note(in_word_t w);
			out_word_t r;
			int need, k, p, j, pages, prev, off, steps, n;
			bit empty;
			r.result_addr = '0;
			r.status = ST_DONE;
			if (w.mode == MODE_ALLOC) begin
				need = int'(w.req_size) + 1;
				if (need <= PAGE_BYTES / 2) begin
					k = 0;
					while ((MIN_CLASS_BYTES << k) < need && k < 15) k++;
					if (clist[k].size() == 0 && fifo.size() == 0) begin
						r.status = ST_OOM;
					end else begin
						if (clist[k].size() == 0) begin
							p = fifo.pop_front();
							kind[p] = KIND_DIV;
							cls[p] = k;
							nxt[p] = NO_PAGE;
							for (int u = 0; u < UNITS; u++) busy[p*UNITS + u] = 0;
							clist[k] = {clist[k], p};
						end
						p = clist[k][0];
						j = lowest(p, k);
						if (j < 0) begin
							unlist(k, p);
							r.status = ST_OOM;
						end else begin
							busy[p*UNITS + (j << k)] = 1;
							if (lowest(p, k) < 0) unlist(k, p);
							r.result_addr = ADDR_W'(p*PAGE_BYTES + (j << k)*MIN_CLASS_BYTES + 1);
						end
					end
				end else begin
					pages = (int'(w.req_size) + PAGE_BYTES - 1) / PAGE_BYTES;
					if (pages > fifo.size()) begin
						r.status = ST_OOM;
					end else begin
						r.result_addr = ADDR_W'(fifo[0] * PAGE_BYTES);
						prev = NO_PAGE;
						for (int i = 0; i < pages; i++) begin
							p = fifo.pop_front();
							kind[p] = KIND_MULTI;
							cls[p] = 0;
							nxt[p] = NO_PAGE;
							if (prev != NO_PAGE) nxt[prev] = p;
							prev = p;
						end
					end
				end
			end else begin
				p = int'(w.req_addr) / PAGE_BYTES;
				off = int'(w.req_addr) % PAGE_BYTES;
				if (kind[p] == KIND_FREE) begin
					r.status = ST_IGN;
				end else if (kind[p] == KIND_DIV) begin
					k = cls[p];
					busy[p*UNITS + ((off / (MIN_CLASS_BYTES << k)) << k)] = 0;
					empty = 1;
					n = UNITS >> k;
					for (int i = 0; i < n; i++) if (busy[p*UNITS + (i << k)]) empty = 0;
					if (empty) begin
						unlist(k, p);
						kind[p] = KIND_FREE;
						cls[p] = 0;
						if (fifo.size() < NUM_PAGES) fifo = {fifo, p};
					end else if (!listed(k, p) && clist[k].size() < NUM_PAGES) begin
						clist[k] = {clist[k], p};
					end
				end else begin
					for (int q = 0; q < NUM_PAGES; q++)
						if (kind[q] == KIND_MULTI && nxt[q] == p) nxt[q] = NO_PAGE;
					steps = 0;
					while (steps < NUM_PAGES && p < NUM_PAGES && kind[p] == KIND_MULTI) begin
						n = nxt[p];
						kind[p] = KIND_FREE;
						cls[p] = 0;
						nxt[p] = NO_PAGE;
						if (fifo.size() < NUM_PAGES) fifo = {fifo, p};
						p = n;
						steps++;
					end
				end
			end
			case (r.status)
				ST_OOM:  ooms++;
				ST_IGN:  ignores++;
				default: if (w.mode == MODE_ALLOC) grants++;
			endcase
			awaited = {awaited, r};
			return r;
		endfunction

		function void check(out_word_t got);
			out_word_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				errors++;
				return;
			end
			want = awaited.pop_front();
			checked++;
			if (got.result_addr !== want.result_addr) begin
				$display("%0t: result_addr expected %h actual %h", $time,
					want.result_addr, got.result_addr);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic      clk = 0;
	logic      arst_n = 0;
	logic      in_valid = 0;
	logic      in_ready;
	in_word_t  in_word = '0;
	logic      out_valid;
	logic      out_ready = 0;
	out_word_t out_word;

	alloc_scoreboard sb = new();
	int        send_idle, recv_stall, cycles;
	int        live [$];

	size_class_page_allocator_core dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[size_class_page_allocator_core] ERROR");
			$finish;
		end
		if (arst_n && out_valid && out_ready) sb.check(out_word);
	end

	always @(negedge clk)
		out_ready = $urandom_range(99) >= recv_stall;

	task automatic send(logic mode, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
		in_word_t  w;
		out_word_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 0;
			in_word = in_word_t'($bits(in_word_t)'($urandom));
			@(negedge clk);
		end
		w.mode = mode;
		w.req_size = size;
		w.req_addr = addr;
		in_word = w;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		r = sb.note(w);
		if (mode == MODE_ALLOC && r.status == ST_DONE) live = {live, int'(r.result_addr)};
	endtask

	task automatic alloc(int size);
		send(MODE_ALLOC, SIZE_W'(size), ADDR_W'($urandom));
	endtask

	task automatic free(int addr);
		send(MODE_FREE, SIZE_W'($urandom), ADDR_W'(addr));
	endtask

	task automatic random_item();
		int i, a;
		if ($urandom_range(99) < 8) begin
			send(1'($urandom_range(1)), SIZE_W'($urandom), ADDR_W'($urandom));
		end else if (live.size() > 0 && $urandom_range(99) < 45) begin
			i = $urandom_range(live.size() - 1);
			a = live[i] + $urandom_range(14) - 1;
			live.delete(i);
			free(a < 0 ? 0 : a);
		end else begin
			case ($urandom_range(9))
				0, 1, 2, 3: alloc($urandom_range(62));
				4, 5, 6:    alloc($urandom_range(2047));
				7:          alloc($urandom_range(12288, 2047));
				8:          alloc($urandom_range(65535, 2048));
				default:    alloc($urandom_range(255));
			endcase
		end
	endtask

	initial begin
		int phase_idle [4] = '{0, 53, 0, 26};
		int phase_stall [4] = '{0, 0, 53, 26};
		send_idle = 0;
		recv_stall = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		sb.clear();

		alloc(0);
		alloc(15);
		alloc(16);
		alloc(2046);
		alloc(2047);
		free(1 + 32);
		free(16 + 5);
		free(1);
		free(1);
		alloc(2048);
		alloc(65535);
		alloc(4097);
		free(12288 + 100);
		free(16383);
		free(0);
		free(8192);
		free(4096);
		alloc(8192);
		alloc(4096);
		free(4096 * 1 + 7);
		free(0);
		free(8192);
		free(12288);
		while (live.size() > 0) free(live.pop_front());

		for (int ph = 0; ph < 4; ph++) begin
			send_idle = phase_idle[ph];
			recv_stall = phase_stall[ph];
			for (int n = 0; n < 470; n++) random_item();
		end

		@(negedge clk);
		in_valid = 0;
		while (sb.awaited.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("Checked %0d result words: %0d grants, %0d out of memory, %0d ignored frees.",
			sb.checked, sb.grants, sb.ooms, sb.ignores);
		$display("Sender idling and receiver stalling varied across four phases.");
		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("[size_class_page_allocator_core] OK");
		end else begin
			$display("[size_class_page_allocator_core] ERROR");
		end
		$finish;
	end
endmodule

// File: sim.f
+incdir+rtl
rtl/scpa_pkg.sv
rtl/scpa_dpath.sv
rtl/scpa_ctrl.sv
rtl/size_class_page_allocator_core.sv
dv/tb_size_class_page_allocator_core.sv
